// ===== src/dia_pkg.sv =====
// ----------------------------------------------------------------------------
// dia_pkg
// Shared types, constants and calendar helpers for the interval alarm core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dia_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int WEEKDAY_W = 3;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int CFG_W     = 8;
    localparam int ADD_H_W   = 3;

    localparam int MIN_PER_HOUR    = 60;
    localparam int MAX_MINUTE      = 59;
    localparam int MAX_HOUR        = 23;
    localparam int HOUR_PER_DAY    = 24;
    localparam int MAX_WEEKDAY     = 6;
    localparam int MONTH_PER_YEAR  = 12;
    localparam int FEB_DAYS        = 28;
    localparam int INTERVAL_MAX    = 240;
    localparam int INTERVAL_RESET  = 60;

    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [WEEKDAY_W-1:0] weekday;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        logic [SECOND_W-1:0]  second;
    } t_time;

    typedef struct packed {
        logic [ADD_H_W-1:0]  hours;
        logic [MINUTE_W-1:0] minutes;
    } t_interval;

    function automatic logic [DAY_W-1:0] month_length(
        input logic [YEAR_W-1:0]  year,
        input logic [MONTH_W-1:0] month
    );
        logic [DAY_W-1:0] len;
        if (month == MON_APR || month == MON_JUN || month == MON_SEP ||
            month == MON_NOV) begin
            len = DAY_W'(FEB_DAYS + 2);
        end else if (month == MON_FEB) begin
            len = (year[1:0] == 2'b00) ? DAY_W'(FEB_DAYS + 1) : DAY_W'(FEB_DAYS);
        end else begin
            len = DAY_W'(FEB_DAYS + 3);
        end
        return len;
    endfunction

endpackage

// ===== src/datetime_interval_alarm_core.sv =====
// ----------------------------------------------------------------------------
// datetime_interval_alarm_core
// Calendar alarm: compares each time sample with the next-due time and
// optionally reschedules it by the configured interval.
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// in       in   i_in_valid / o_in_stall   i_func, i_now_*
// out      out  o_out_valid / i_out_stall o_due, o_next_*_out
// cfg      in   i_cfg_valid / o_cfg_ready i_cfg_data (interval minutes)
//
// One beat per cycle sustained while the output is not stalled; an accepted
// beat reaches the output through the input register, then the result register.
// The next-due time updates as a beat moves into the result register, so
// the following beat compares against it with no bubble.
// Reset (synchronous, active low) empties both stages, clears next-due and
// sets the interval to 60 minutes. The input stalls only when both stages
// are full and the output is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module datetime_interval_alarm_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [dia_pkg::YEAR_W-1:0]    i_now_year,
    input  logic [dia_pkg::MONTH_W-1:0]   i_now_month,
    input  logic [dia_pkg::DAY_W-1:0]     i_now_day,
    input  logic [dia_pkg::WEEKDAY_W-1:0] i_now_weekday,
    input  logic [dia_pkg::HOUR_W-1:0]    i_now_hour,
    input  logic [dia_pkg::MINUTE_W-1:0]  i_now_minute,
    input  logic [dia_pkg::SECOND_W-1:0]  i_now_second,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_due,
    output logic [dia_pkg::YEAR_W-1:0]    o_next_year_out,
    output logic [dia_pkg::MONTH_W-1:0]   o_next_month_out,
    output logic [dia_pkg::DAY_W-1:0]     o_next_day_out,
    output logic [dia_pkg::WEEKDAY_W-1:0] o_next_weekday_out,
    output logic [dia_pkg::HOUR_W-1:0]    o_next_hour_out,
    output logic [dia_pkg::MINUTE_W-1:0]  o_next_minute_out,
    output logic [dia_pkg::SECOND_W-1:0]  o_next_second_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dia_pkg::CFG_W-1:0]     i_cfg_data
);
    import dia_pkg::*;

    logic       r_in_valid;
    logic       r_in_func;
    t_time      r_in_now;
    t_time      r_due_at;
    logic       r_out_valid;
    logic       r_out_due;
    t_time      r_out_next;
    t_interval  interval;
    logic       calc_due;
    t_time      n_due_at;
    logic       advance;
    logic       in_take;

    assign o_cfg_ready = 1'b1;

    dia_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_data  (i_cfg_data),
        .o_interval (interval)
    );

    dia_calc u_calc (
        .i_func     (r_in_func),
        .i_now      (r_in_now),
        .i_due_at   (r_due_at),
        .i_interval (interval),
        .o_due      (calc_due),
        .o_next     (n_due_at)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_due_at    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_due_at    <= n_due_at;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func        <= i_func;
            r_in_now.year    <= i_now_year;
            r_in_now.month   <= i_now_month;
            r_in_now.day     <= i_now_day;
            r_in_now.weekday <= i_now_weekday;
            r_in_now.hour    <= i_now_hour;
            r_in_now.minute  <= i_now_minute;
            r_in_now.second  <= i_now_second;
        end
        if (advance) begin
            r_out_due  <= calc_due;
            r_out_next <= n_due_at;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_due              = r_out_due;
    assign o_next_year_out    = r_out_next.year;
    assign o_next_month_out   = r_out_next.month;
    assign o_next_day_out     = r_out_next.day;
    assign o_next_weekday_out = r_out_next.weekday;
    assign o_next_hour_out    = r_out_next.hour;
    assign o_next_minute_out  = r_out_next.minute;
    assign o_next_second_out  = r_out_next.second;

endmodule

// ===== src/dia_cfg.sv =====
// ----------------------------------------------------------------------------
// dia_cfg
// Interval register: clamps writes and keeps the value as hours and minutes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dia_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [dia_pkg::CFG_W-1:0] i_wr_data,
    output dia_pkg::t_interval        o_interval
);
    import dia_pkg::*;

    t_interval         r_interval;
    t_interval         n_interval;
    logic [CFG_W-1:0]  clamped;
    logic [CFG_W-1:0]  rem;

    always_comb begin
        clamped = (i_wr_data > CFG_W'(INTERVAL_MAX)) ? CFG_W'(INTERVAL_MAX) : i_wr_data;
        priority if (clamped >= CFG_W'(4 * MIN_PER_HOUR)) begin
            n_interval.hours = ADD_H_W'(4);
            rem = clamped - CFG_W'(4 * MIN_PER_HOUR);
        end else if (clamped >= CFG_W'(3 * MIN_PER_HOUR)) begin
            n_interval.hours = ADD_H_W'(3);
            rem = clamped - CFG_W'(3 * MIN_PER_HOUR);
        end else if (clamped >= CFG_W'(2 * MIN_PER_HOUR)) begin
            n_interval.hours = ADD_H_W'(2);
            rem = clamped - CFG_W'(2 * MIN_PER_HOUR);
        end else if (clamped >= CFG_W'(MIN_PER_HOUR)) begin
            n_interval.hours = ADD_H_W'(1);
            rem = clamped - CFG_W'(MIN_PER_HOUR);
        end else begin
            n_interval.hours = ADD_H_W'(0);
            rem = clamped;
        end
        n_interval.minutes = rem[MINUTE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval.hours   <= ADD_H_W'(INTERVAL_RESET / MIN_PER_HOUR);
            r_interval.minutes <= MINUTE_W'(INTERVAL_RESET % MIN_PER_HOUR);
        end else if (i_wr_en) begin
            r_interval <= n_interval;
        end
    end

    assign o_interval = r_interval;

endmodule

// ===== src/dia_calc.sv =====
// ----------------------------------------------------------------------------
// dia_calc
// Compare against next-due time and compute the rescheduled next-due time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dia_calc (
    input  logic               i_func,
    input  dia_pkg::t_time     i_now,
    input  dia_pkg::t_time     i_due_at,
    input  dia_pkg::t_interval i_interval,
    output logic               o_due,
    output dia_pkg::t_time     o_next
);
    import dia_pkg::*;

    logic [MINUTE_W:0]    mi_sum;
    logic [HOUR_W:0]      h_sum;
    logic [DAY_W:0]       d_sum;
    logic [WEEKDAY_W:0]   wd_sum;
    logic [MONTH_W:0]     mo_sum;
    logic [DAY_W-1:0]     len;
    logic                 carry_m;
    logic                 carry_h;
    logic                 carry_d;
    logic                 carry_mo;
    logic [MINUTE_W:0]    mi_fix;
    logic [HOUR_W:0]      h_fix;
    logic [DAY_W:0]       d_fix;
    logic [MONTH_W:0]     mo_fix;
    t_time                sched;

    always_comb begin
        priority if (i_now.year != i_due_at.year) begin
            o_due = i_now.year > i_due_at.year;
        end else if (i_now.month != i_due_at.month) begin
            o_due = i_now.month > i_due_at.month;
        end else if (i_now.day != i_due_at.day) begin
            o_due = i_now.day > i_due_at.day;
        end else if (i_now.hour != i_due_at.hour) begin
            o_due = i_now.hour > i_due_at.hour;
        end else if (i_now.minute != i_due_at.minute) begin
            o_due = i_now.minute > i_due_at.minute;
        end else begin
            o_due = i_now.second > i_due_at.second;
        end
    end

    always_comb begin
        mi_sum  = {1'b0, i_now.minute} + {1'b0, i_interval.minutes};
        carry_m = mi_sum > (MINUTE_W+1)'(MAX_MINUTE);
        mi_fix  = carry_m ? mi_sum - (MINUTE_W+1)'(MIN_PER_HOUR) : mi_sum;

        h_sum   = {1'b0, i_now.hour} + (HOUR_W+1)'(carry_m)
                + (HOUR_W+1)'(i_interval.hours);
        carry_h = h_sum > (HOUR_W+1)'(MAX_HOUR);
        h_fix   = carry_h ? h_sum - (HOUR_W+1)'(HOUR_PER_DAY) : h_sum;

        d_sum   = {1'b0, i_now.day} + (DAY_W+1)'(carry_h);
        wd_sum  = {1'b0, i_now.weekday} + (WEEKDAY_W+1)'(carry_h);

        len     = month_length(i_now.year, i_now.month);
        carry_d = d_sum > {1'b0, len};
        d_fix   = carry_d ? d_sum - {1'b0, len} : d_sum;

        mo_sum   = {1'b0, i_now.month} + (MONTH_W+1)'(carry_d);
        carry_mo = mo_sum > (MONTH_W+1)'(MONTH_PER_YEAR);
        mo_fix   = carry_mo ? mo_sum - (MONTH_W+1)'(MONTH_PER_YEAR) : mo_sum;

        sched.year    = i_now.year + YEAR_W'(carry_mo);
        sched.month   = mo_fix[MONTH_W-1:0];
        sched.day     = d_fix[DAY_W-1:0];
        sched.weekday = (wd_sum > (WEEKDAY_W+1)'(MAX_WEEKDAY)) ? '0
                      : wd_sum[WEEKDAY_W-1:0];
        sched.hour    = h_fix[HOUR_W-1:0];
        sched.minute  = mi_fix[MINUTE_W-1:0];
        sched.second  = i_now.second;

        o_next = i_func ? sched : i_due_at;
    end

endmodule

// ===== src/dia_checker.sv =====
// ----------------------------------------------------------------------------
// dia_checker
// Port-level checks for the interval alarm core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dia_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [dia_pkg::WEEKDAY_W-1:0] o_next_weekday_out
);
    import dia_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> ##1 o_out_valid)
        else $error("accepted beat did not reach output in two cycles");

    a_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_next_weekday_out <= WEEKDAY_W'(MAX_WEEKDAY))
        else $error("next-due weekday out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind datetime_interval_alarm_core dia_checker u_dia_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_next_weekday_out (o_next_weekday_out)
);
